/* hw/rtl/table_interp_temperature_macros.svh */
// Assertion macros for the table interpolation block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef TABLE_INTERP_TEMPERATURE_MACROS_SVH
`define TABLE_INTERP_TEMPERATURE_MACROS_SVH

// same-cycle implication
`define TBLINT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TBLINT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/tblint_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and job format for the table interpolation block.
// No dependencies.
package tblint_pkg;

  localparam int TABLE_MAX   = 32;
  localparam int IDX_W       = $clog2(TABLE_MAX);
  localparam int CNT_W       = $clog2(TABLE_MAX + 1);
  localparam int LEN_W       = 6;
  localparam int CODE_W      = 12;
  localparam int TEMP_W      = 16;
  localparam int ENTRY_IDX_W = 5;
  localparam int DT_W        = TEMP_W + 1;
  localparam int PROD_W      = DT_W + CODE_W + 1;
  localparam int MAG_W       = TEMP_W + CODE_W;
  localparam int SUM_W       = TEMP_W + 2;
  localparam int RAM_W       = CODE_W + TEMP_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [LEN_W-1:0] LEN_RESET        = LEN_W'(1);
  localparam logic             REG_TABLE_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_LOAD,
    OP_CONV
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic [IDX_W-1:0]         idx;
    logic [CODE_W-1:0]        code;
    logic signed [TEMP_W-1:0] temp;
    logic [CODE_W-1:0]        adc;
  } job_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } back_stat_t;

endpackage

/* hw/rtl/tblint_req_if.sv */
`timescale 1ns / 1ps
// Input channel: load and convert requests.
// Depends on tblint_pkg.
interface tblint_req_if;
  import tblint_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [ENTRY_IDX_W-1:0]        entry_index;
  logic [CODE_W-1:0]             entry_code;
  logic signed [TEMP_W-1:0]      entry_temp;
  logic [CODE_W-1:0]             adc_code;

  modport source (output valid, req_type, entry_index, entry_code, entry_temp, adc_code,
                  input ready);
  modport sink   (input valid, req_type, entry_index, entry_code, entry_temp, adc_code,
                  output ready);
endinterface

/* hw/rtl/tblint_rsp_if.sv */
`timescale 1ns / 1ps
// Result channel: interpolated temperature.
// Depends on tblint_pkg.
interface tblint_rsp_if;
  import tblint_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temp_x10;

  modport source (output valid, temp_x10, input ready);
  modport sink   (input valid, temp_x10, output ready);
endinterface

/* hw/rtl/tblint_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tblint_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/tblint_div.sv */
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tblint_pkg.
module tblint_div
  import tblint_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MAG_W-1:0]  dividend,
  input  logic [CODE_W-1:0] divisor,
  output logic              done,
  output logic [MAG_W-1:0]  quot
);

  localparam int DCNT_W = $clog2(MAG_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [CODE_W:0]   rem_r;
  logic [MAG_W-1:0]  quo_r;
  logic [CODE_W-1:0] den_r;

  logic [CODE_W:0] shifted;
  logic [CODE_W:0] diff;
  logic            ge;

  always_comb begin
    shifted = {rem_r[CODE_W-1:0], quo_r[MAG_W-1]};
    ge      = shifted >= {1'b0, den_r};
    diff    = shifted - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(MAG_W);
        rem_r  <= '0;
        quo_r  <= dividend;
        den_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? diff : shifted;
        quo_r <= {quo_r[MAG_W-2:0], ge};
        cnt_r <= cnt_r - DCNT_W'(1);
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

/* hw/rtl/tblint_front.sv */
`timescale 1ns / 1ps
// Front end: accepts request beats, classifies them, queues jobs for the back end.
// Depends on tblint_pkg and tblint_req_if.
module tblint_front
  import tblint_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  tblint_req_if.sink  in_chan,
  output job_t        job,
  output logic        job_valid,
  input  logic        job_pop
);

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  job_t new_job;
  logic accept;
  logic push;

  always_comb begin
    new_job.idx  = IDX_W'(in_chan.entry_index);
    new_job.code = in_chan.entry_code;
    new_job.temp = in_chan.entry_temp;
    new_job.adc  = in_chan.adc_code;
    if (in_chan.req_type) begin
      new_job.op = OP_CONV;
    end else if (32'(in_chan.entry_index) < 32'(TABLE_MAX)) begin
      new_job.op = OP_LOAD;
    end else begin
      new_job.op = OP_NOP;
    end
  end

  assign in_chan.ready = cnt_r != QCNT_W'(QUEUE_DEPTH);
  assign accept        = in_chan.valid && in_chan.ready;
  assign push          = accept && (new_job.op != OP_NOP);
  assign job_valid     = cnt_r != '0;
  assign job           = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        q_r[wr_ptr_r] <= new_job;
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (job_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !job_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (!push && job_pop) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

/* hw/rtl/tblint_back.sv */
`timescale 1ns / 1ps
// Back end: table memory, sequential search, multiply and serial divide, result register.
// Depends on tblint_pkg, tblint_ram, tblint_div and tblint_rsp_if.
module tblint_back
  import tblint_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CNT_W-1:0]  npts,
  input  job_t              job,
  input  logic              job_valid,
  output back_stat_t        stat,
  tblint_rsp_if.source      out_chan
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_SCAN,
    S_MUL,
    S_DSTART,
    S_DIV,
    S_PUT
  } state_t;

  state_t                   state_r;
  logic [CODE_W-1:0]        adc_r;
  logic [IDX_W-1:0]         idx_r;
  logic [CODE_W-1:0]        prev_code_r;
  logic signed [TEMP_W-1:0] prev_temp_r;
  logic signed [DT_W-1:0]   dt_r;
  logic [CODE_W-1:0]        dx_r;
  logic [CODE_W-1:0]        den_r;
  logic signed [TEMP_W-1:0] base_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     neg_r;
  logic signed [TEMP_W-1:0] res_r;
  logic                     out_valid_r;
  logic signed [TEMP_W-1:0] out_temp_r;

  logic                     ram_we;
  logic                     ram_re;
  logic [IDX_W-1:0]         ram_raddr;
  logic [RAM_W-1:0]         ram_rdata;
  logic [CODE_W-1:0]        rd_code;
  logic signed [TEMP_W-1:0] rd_temp;
  logic signed [CODE_W:0]   den_c;
  logic signed [PROD_W-1:0] prod_abs;
  logic                     div_start;
  logic                     div_done;
  logic [MAG_W-1:0]         div_quot;
  logic signed [SUM_W-1:0]  qs;
  logic signed [SUM_W-1:0]  sum;
  logic                     is_last;

  tblint_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_MAX)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (job.idx),
    .wdata ({job.code, job.temp}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tblint_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_abs[MAG_W-1:0]),
    .divisor  (den_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_comb begin
    rd_code   = ram_rdata[TEMP_W +: CODE_W];
    rd_temp   = $signed(ram_rdata[TEMP_W-1:0]);
    den_c     = $signed({1'b0, rd_code}) - $signed({1'b0, prev_code_r});
    prod_abs  = prod_r[PROD_W-1] ? -prod_r : prod_r;
    qs        = $signed({1'b0, div_quot[TEMP_W:0]});
    sum       = SUM_W'(base_r) + (neg_r ? -qs : qs);
    is_last   = CNT_W'(idx_r) == (npts - CNT_W'(1));
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    div_start = 1'b0;
    stat.pop  = 1'b0;
    stat.busy = state_r != S_IDLE;
    case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          stat.pop = 1'b1;
          ram_we   = job.op == OP_LOAD;
          ram_re   = job.op == OP_CONV;
        end
      end
      S_FIRST: begin
        ram_re    = 1'b1;
        ram_raddr = IDX_W'(1);
      end
      S_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r + IDX_W'(1);
      end
      S_DSTART: begin
        div_start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_chan.ready && state_r != S_PUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (job_valid && job.op == OP_CONV) begin
            adc_r   <= job.adc;
            state_r <= S_FIRST;
          end
        end
        S_FIRST: begin
          if (adc_r <= rd_code || npts == CNT_W'(1)) begin
            res_r   <= rd_temp;
            state_r <= S_PUT;
          end else begin
            prev_code_r <= rd_code;
            prev_temp_r <= rd_temp;
            idx_r       <= IDX_W'(1);
            state_r     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (adc_r <= rd_code) begin
            if (den_c <= 0) begin
              res_r   <= rd_temp;
              state_r <= S_PUT;
            end else begin
              dt_r    <= DT_W'(rd_temp) - DT_W'(prev_temp_r);
              dx_r    <= adc_r - prev_code_r;
              den_r   <= den_c[CODE_W-1:0];
              base_r  <= prev_temp_r;
              state_r <= S_MUL;
            end
          end else if (is_last) begin
            res_r   <= rd_temp;
            state_r <= S_PUT;
          end else begin
            prev_code_r <= rd_code;
            prev_temp_r <= rd_temp;
            idx_r       <= idx_r + IDX_W'(1);
          end
        end
        S_MUL: begin
          prod_r  <= PROD_W'(dt_r) * PROD_W'($signed({1'b0, dx_r}));
          state_r <= S_DSTART;
        end
        S_DSTART: begin
          neg_r   <= prod_r[PROD_W-1];
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res_r   <= sum[TEMP_W-1:0];
            state_r <= S_PUT;
          end
        end
        S_PUT: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_temp_r  <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.temp_x10 = out_temp_r;

endmodule

/* hw/rtl/table_interp_temperature.sv */
`timescale 1ns / 1ps
// Top level of the thermistor table interpolation block: config register, front, back.
// Depends on tblint_pkg, the channel interfaces, tblint_front, tblint_back and the macros.
//
//   channel   dir   handshake         payload
//   in_chan   in    valid / ready     req_type, entry_index, entry_code, entry_temp, adc_code
//   out_chan  out   valid / ready     temp_x10
//   cfg       in    APB psel/penable  table_length at byte address 0
//
// A load beat is written to table memory by the back end; a convert beat searches the table
// point by point and, when it interpolates, multiplies and runs a 28-step divide.
// Reset is synchronous and active low; the table memory keeps its contents across reset.
// A two-entry job queue lets input beats be accepted while the back end or out_chan stalls.
`include "table_interp_temperature_macros.svh"
module table_interp_temperature
  import tblint_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  tblint_req_if.sink         in_chan,
  tblint_rsp_if.source       out_chan,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [LEN_W-1:0] len_r;
  logic [CNT_W-1:0] npts;
  job_t             job;
  logic             job_valid;
  back_stat_t       stat;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2] == REG_TABLE_LENGTH;
  assign prdata  = reg_sel ? PDATA_W'(len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      len_r <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    if (len_r == '0) begin
      npts = CNT_W'(1);
    end else if (32'(len_r) > 32'(TABLE_MAX)) begin
      npts = CNT_W'(TABLE_MAX);
    end else begin
      npts = CNT_W'(len_r);
    end
  end

  tblint_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .job       (job),
    .job_valid (job_valid),
    .job_pop   (stat.pop)
  );

  tblint_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .npts      (npts),
    .job       (job),
    .job_valid (job_valid),
    .stat      (stat),
    .out_chan  (out_chan)
  );

  `TBLINT_ASSERT_NOW(a_pop_valid, stat.pop, job_valid, "job popped from empty queue")
  `TBLINT_ASSERT_NOW(a_npts_range, 1'b1, npts != '0 && npts <= CNT_W'(TABLE_MAX), "bad point count")
  `TBLINT_ASSERT_NEXT(a_no_stray_result, !stat.busy && !job_valid, !$rose(out_chan.valid), "result without job")

endmodule
